// File: hw/rtl/aftp_pkg.sv
// ----------------------------------------------------------------------------
// aftp_pkg: shared types and constants of the affinity fair task picker
// Holds the table sizes, the item codes, the controller commands and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package aftp_pkg;

	localparam int NUM_SLOTS  = 16;
	localparam int SLOT_W     = 4;
	localparam int QLEN_W     = 5;
	localparam int CPU_W      = 2;
	localparam int AFF_W      = 4;
	localparam int GRP_W      = 16;
	localparam int WL_W       = 16;
	localparam int NICE_W     = 8;
	localparam int SLICE_W    = 9;
	localparam int HIST_DEPTH = 400;
	localparam int HPTR_W     = 9;

	// Shared restoring divider: dividend, divisor and step counter widths.
	localparam int DIV_W     = 18;
	localparam int DVS_W     = 17;
	localparam int DIV_STEPS = 18;
	localparam int CNT_W     = 5;

	localparam logic [SLICE_W-1:0] SLICE_MAX = '1;
	localparam logic [SLICE_W-1:0] NICE_BASE = SLICE_W'(10);

	// Division by ten as a multiply by ceil(2^21 / 10) and a shift by 21.
	// The result is exact for every dividend below 2^18.
	localparam logic [DIV_W-1:0] TEN_RECIP = DIV_W'(209716);
	localparam int               TEN_SHIFT = 21;

	typedef enum logic [1:0] {
		MODE_UPDATE = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_PICK   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_NONE = 2'd1,
		ST_DUP  = 2'd2,
		ST_NOTQ = 2'd3
	} stat_t;

	// Controller states; the current state is also the datapath command.
	typedef enum logic [3:0] {
		OP_IDLE,
		OP_EXEC,
		OP_FIND,
		OP_SHIFT,
		OP_SCAN,
		OP_DIV_A,
		OP_MUL,
		OP_DIV_B,
		OP_CMP,
		OP_FALL,
		OP_PSEL,
		OP_HRD,
		OP_HDEC,
		OP_HINC,
		OP_RESP
	} op_t;

	typedef struct packed {
		op_t  op;
		logic load;
		logic res_load;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  queued_hit;
		logic  idx_end;
		logic  eligible;
		logic  fall_hit;
		logic  find_hit;
		logic  shift_last;
		logic  div_last;
		logic  found;
	} sts_t;

endpackage

// File: hw/rtl/aftp_ctrl.sv
// ----------------------------------------------------------------------------
// aftp_ctrl: controller of the affinity fair task picker
// Sequences each item through the datapath and owns the input and output
// handshakes.
// ----------------------------------------------------------------------------
module aftp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  aftp_pkg::sts_t  sts,
	output aftp_pkg::cmd_t  cmd
);

	aftp_pkg::op_t state_q, state_d;
	logic          out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aftp_pkg::OP_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.op       = state_q;
		cmd.load     = 1'b0;
		cmd.res_load = 1'b0;
		unique case (state_q)
			aftp_pkg::OP_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = aftp_pkg::OP_EXEC;
				end
			end
			aftp_pkg::OP_EXEC: begin
				unique case (sts.mode)
					aftp_pkg::MODE_REMOVE:
						state_d = sts.queued_hit ? aftp_pkg::OP_FIND : aftp_pkg::OP_RESP;
					aftp_pkg::MODE_PICK: state_d = aftp_pkg::OP_SCAN;
					default: state_d = aftp_pkg::OP_RESP;
				endcase
			end
			aftp_pkg::OP_FIND: begin
				if (sts.find_hit) state_d = aftp_pkg::OP_SHIFT;
			end
			aftp_pkg::OP_SHIFT: begin
				if (sts.shift_last) begin
					state_d = (sts.mode == aftp_pkg::MODE_PICK) ? aftp_pkg::OP_HRD
						: aftp_pkg::OP_RESP;
				end
			end
			aftp_pkg::OP_SCAN: begin
				if (sts.idx_end) begin
					state_d = sts.found ? aftp_pkg::OP_PSEL : aftp_pkg::OP_FALL;
				end else if (sts.eligible) begin
					state_d = aftp_pkg::OP_DIV_A;
				end
			end
			aftp_pkg::OP_DIV_A: begin
				if (sts.div_last) state_d = aftp_pkg::OP_MUL;
			end
			aftp_pkg::OP_MUL:   state_d = aftp_pkg::OP_DIV_B;
			aftp_pkg::OP_DIV_B: state_d = aftp_pkg::OP_CMP;
			aftp_pkg::OP_CMP:   state_d = aftp_pkg::OP_SCAN;
			aftp_pkg::OP_FALL: begin
				if (sts.idx_end) begin
					state_d = aftp_pkg::OP_RESP;
				end else if (sts.fall_hit) begin
					state_d = aftp_pkg::OP_PSEL;
				end
			end
			aftp_pkg::OP_PSEL:  state_d = aftp_pkg::OP_SHIFT;
			aftp_pkg::OP_HRD:   state_d = aftp_pkg::OP_HDEC;
			aftp_pkg::OP_HDEC:  state_d = aftp_pkg::OP_HINC;
			aftp_pkg::OP_HINC:  state_d = aftp_pkg::OP_RESP;
			aftp_pkg::OP_RESP: begin
				if (!out_valid_q || !out_stall) begin
					cmd.res_load = 1'b1;
					state_d      = aftp_pkg::OP_IDLE;
				end
			end
			default: state_d = aftp_pkg::OP_IDLE;
		endcase
	end

	assign in_stall  = (state_q != aftp_pkg::OP_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: hw/rtl/aftp_dp.sv
// ----------------------------------------------------------------------------
// aftp_dp: datapath of the affinity fair task picker
// Task table, ready queue, history ring memory, shared divider and the
// result registers.
// ----------------------------------------------------------------------------
module aftp_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  aftp_pkg::cmd_t                    cmd,
	output aftp_pkg::sts_t                    sts,
	input  logic [1:0]                        mode,
	input  logic [aftp_pkg::SLOT_W-1:0]       slot,
	input  logic [aftp_pkg::CPU_W-1:0]        cpu,
	input  logic [aftp_pkg::GRP_W-1:0]        group_number,
	input  logic [aftp_pkg::WL_W-1:0]         workload,
	input  logic [aftp_pkg::NICE_W-1:0]       niceness,
	input  logic [aftp_pkg::AFF_W-1:0]        cpu_mask,
	input  logic                              kernel_task,
	output logic [1:0]                        status,
	output logic [aftp_pkg::SLOT_W-1:0]       picked_slot,
	output logic [aftp_pkg::SLICE_W-1:0]      picked_slices
);

	localparam int NS = aftp_pkg::NUM_SLOTS;

	// Captured item.
	aftp_pkg::mode_t                   mode_q;
	logic [aftp_pkg::SLOT_W-1:0]       slot_q;
	logic [aftp_pkg::CPU_W-1:0]        cpu_q;
	logic [aftp_pkg::GRP_W-1:0]        grp_in_q;
	logic [aftp_pkg::WL_W-1:0]         wl_in_q;
	logic [aftp_pkg::NICE_W-1:0]       nice_in_q;
	logic [aftp_pkg::AFF_W-1:0]        aff_in_q;
	logic                              kern_in_q;

	// Task table and ready queue.
	logic [aftp_pkg::GRP_W-1:0]   grp_q   [NS];
	logic [aftp_pkg::WL_W-1:0]    wl_q    [NS];
	logic [aftp_pkg::NICE_W-1:0]  nice_q  [NS];
	logic [aftp_pkg::AFF_W-1:0]   aff_q   [NS];
	logic [NS-1:0]                kern_q;
	logic [aftp_pkg::SLICE_W-1:0] slc_q   [NS];
	logic [NS-1:0]                queued_q;
	logic [aftp_pkg::SLOT_W-1:0]  queue_q [NS];
	logic [aftp_pkg::QLEN_W-1:0]  qlen_q;

	// History ring; valid entries are those below the pointer until it wraps.
	logic [aftp_pkg::SLOT_W-1:0]  hist_mem [aftp_pkg::HIST_DEPTH];
	logic [aftp_pkg::SLOT_W-1:0]  hist_rd_q;
	logic [aftp_pkg::HPTR_W-1:0]  hptr_q;
	logic                         hfull_q;

	// Scan state.
	logic [aftp_pkg::QLEN_W-1:0]  idx_q;
	logic [aftp_pkg::SLOT_W-1:0]  best_pos_q;
	logic [aftp_pkg::GRP_W-1:0]   best_grp_q;
	logic [aftp_pkg::DIV_W-1:0]   best_load_q;
	logic                         found_q;
	logic [aftp_pkg::SLOT_W-1:0]  drop_q;

	// Divider.
	logic [aftp_pkg::DVS_W-1:0]   rem_q;
	logic [aftp_pkg::DIV_W-1:0]   quo_q;
	logic [aftp_pkg::DVS_W-1:0]   dvs_q;
	logic [aftp_pkg::CNT_W-1:0]   cnt_q;

	// Result.
	aftp_pkg::stat_t              st_q;
	logic [aftp_pkg::SLOT_W-1:0]  pslot_q;
	logic [aftp_pkg::SLICE_W-1:0] pl_q;
	logic [1:0]                   res_st_q;
	logic [aftp_pkg::SLOT_W-1:0]  res_slot_q;
	logic [aftp_pkg::SLICE_W-1:0] res_slc_q;

	logic [aftp_pkg::SLOT_W-1:0]  qaddr;
	logic [aftp_pkg::SLOT_W-1:0]  qrd;
	logic [aftp_pkg::SLOT_W-1:0]  taddr;
	logic [aftp_pkg::DIV_W-1:0]   div_sh;
	logic                         div_ge;
	logic [aftp_pkg::DIV_W-1:0]   prod;
	logic [2*aftp_pkg::DIV_W-1:0] scaled;
	logic                         better;
	logic                         idx_in_q;

	assign idx_in_q = (idx_q < qlen_q);

	// One queue read address per cycle.
	always_comb begin
		case (cmd.op)
			aftp_pkg::OP_SHIFT: qaddr = aftp_pkg::SLOT_W'(idx_q + 1'b1);
			aftp_pkg::OP_PSEL:  qaddr = best_pos_q;
			default:            qaddr = idx_q[aftp_pkg::SLOT_W-1:0];
		endcase
	end
	assign qrd = queue_q[qaddr];

	// One task table read address per cycle.
	always_comb begin
		case (cmd.op)
			aftp_pkg::OP_HDEC: taddr = hist_rd_q;
			aftp_pkg::OP_HINC: taddr = pslot_q;
			aftp_pkg::OP_EXEC: taddr = slot_q;
			default:           taddr = qrd;
		endcase
	end

	assign div_sh = {rem_q, quo_q[aftp_pkg::DIV_W-1]};
	assign div_ge = (div_sh >= {1'b0, dvs_q});
	assign prod   = aftp_pkg::DIV_W'(quo_q[aftp_pkg::SLICE_W-1:0])
		* aftp_pkg::DIV_W'(aftp_pkg::NICE_BASE + aftp_pkg::SLICE_W'(nice_q[taddr]));
	assign scaled = {{aftp_pkg::DIV_W{1'b0}}, quo_q}
		* {{aftp_pkg::DIV_W{1'b0}}, aftp_pkg::TEN_RECIP};
	assign better = !found_q || (grp_q[taddr] < best_grp_q)
		|| ((grp_q[taddr] == best_grp_q) && (quo_q < best_load_q));

	always_comb begin
		sts.mode       = mode_q;
		sts.queued_hit = queued_q[slot_q];
		sts.idx_end    = !idx_in_q;
		sts.eligible   = !kern_q[taddr] && aff_q[taddr][cpu_q];
		sts.fall_hit   = aff_q[taddr][cpu_q];
		sts.find_hit   = (qrd == slot_q);
		sts.shift_last = !((idx_q + 1'b1) < qlen_q);
		sts.div_last   = (cnt_q == aftp_pkg::CNT_W'(aftp_pkg::DIV_STEPS - 1));
		sts.found      = found_q;
	end

	// History memory: write on the increment step, read every cycle.
	always_ff @(posedge clk) begin
		if (cmd.op == aftp_pkg::OP_HINC) hist_mem[hptr_q] <= pslot_q;
		hist_rd_q <= hist_mem[hptr_q];
	end

	// Payload registers without reset.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q    <= aftp_pkg::mode_t'(mode);
			slot_q    <= slot;
			cpu_q     <= cpu;
			grp_in_q  <= group_number;
			wl_in_q   <= workload;
			nice_in_q <= niceness;
			aff_in_q  <= cpu_mask;
			kern_in_q <= kernel_task;
		end
		if (cmd.res_load) begin
			res_st_q   <= st_q;
			res_slot_q <= pslot_q;
			res_slc_q  <= pl_q;
		end
		case (cmd.op)
			aftp_pkg::OP_SCAN: begin
				rem_q <= '0;
				quo_q <= aftp_pkg::DIV_W'(slc_q[taddr]);
				dvs_q <= aftp_pkg::DVS_W'(wl_q[taddr]) + 1'b1;
				cnt_q <= '0;
			end
			aftp_pkg::OP_MUL: begin
				quo_q <= prod;
			end
			aftp_pkg::OP_DIV_A: begin
				rem_q <= div_ge ? aftp_pkg::DVS_W'(div_sh - {1'b0, dvs_q})
					: div_sh[aftp_pkg::DVS_W-1:0];
				quo_q <= {quo_q[aftp_pkg::DIV_W-2:0], div_ge};
				cnt_q <= cnt_q + 1'b1;
			end
			aftp_pkg::OP_DIV_B: begin
				quo_q <= aftp_pkg::DIV_W'(scaled[2*aftp_pkg::DIV_W-1:aftp_pkg::TEN_SHIFT]);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) begin
				grp_q[i]   <= '0;
				wl_q[i]    <= '0;
				nice_q[i]  <= '0;
				aff_q[i]   <= '0;
				slc_q[i]   <= '0;
				queue_q[i] <= '0;
			end
			kern_q      <= '0;
			queued_q    <= '0;
			qlen_q      <= '0;
			hptr_q      <= '0;
			hfull_q     <= 1'b0;
			idx_q       <= '0;
			best_pos_q  <= '0;
			best_grp_q  <= '0;
			best_load_q <= '0;
			found_q     <= 1'b0;
			drop_q      <= '0;
			st_q        <= aftp_pkg::ST_OK;
			pslot_q     <= '0;
			pl_q        <= '0;
		end else begin
			if (cmd.load) begin
				st_q    <= aftp_pkg::ST_OK;
				pslot_q <= '0;
				pl_q    <= '0;
				found_q <= 1'b0;
				idx_q   <= '0;
			end
			case (cmd.op)
				aftp_pkg::OP_EXEC: begin
					unique case (mode_q)
						aftp_pkg::MODE_UPDATE: begin
							grp_q[slot_q]  <= grp_in_q;
							wl_q[slot_q]   <= wl_in_q;
							nice_q[slot_q] <= nice_in_q;
							aff_q[slot_q]  <= aff_in_q;
							kern_q[slot_q] <= kern_in_q;
						end
						aftp_pkg::MODE_APPEND: begin
							if (queued_q[slot_q]) begin
								st_q <= aftp_pkg::ST_DUP;
							end else if (qlen_q < aftp_pkg::QLEN_W'(NS)) begin
								queue_q[qlen_q[aftp_pkg::SLOT_W-1:0]] <= slot_q;
								qlen_q           <= qlen_q + 1'b1;
								queued_q[slot_q] <= 1'b1;
							end
						end
						aftp_pkg::MODE_REMOVE: begin
							if (!queued_q[slot_q]) st_q <= aftp_pkg::ST_NOTQ;
							drop_q <= slot_q;
						end
						default: ;
					endcase
				end
				aftp_pkg::OP_FIND: begin
					if (qrd != slot_q) idx_q <= idx_q + 1'b1;
				end
				aftp_pkg::OP_SHIFT: begin
					if ((idx_q + 1'b1) < qlen_q) begin
						queue_q[idx_q[aftp_pkg::SLOT_W-1:0]] <= qrd;
						idx_q <= idx_q + 1'b1;
					end else begin
						qlen_q           <= qlen_q - 1'b1;
						queued_q[drop_q] <= 1'b0;
					end
				end
				aftp_pkg::OP_SCAN: begin
					if (!idx_in_q) begin
						idx_q <= '0;
					end else if (kern_q[taddr] || !aff_q[taddr][cpu_q]) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				aftp_pkg::OP_CMP: begin
					if (better) begin
						found_q     <= 1'b1;
						best_pos_q  <= idx_q[aftp_pkg::SLOT_W-1:0];
						best_grp_q  <= grp_q[taddr];
						best_load_q <= quo_q;
					end
					idx_q <= idx_q + 1'b1;
				end
				aftp_pkg::OP_FALL: begin
					if (!idx_in_q) begin
						st_q <= aftp_pkg::ST_NONE;
					end else if (aff_q[taddr][cpu_q]) begin
						found_q    <= 1'b1;
						best_pos_q <= idx_q[aftp_pkg::SLOT_W-1:0];
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				aftp_pkg::OP_PSEL: begin
					idx_q   <= aftp_pkg::QLEN_W'(best_pos_q);
					drop_q  <= qrd;
					pslot_q <= qrd;
				end
				aftp_pkg::OP_HDEC: begin
					if (hfull_q && (slc_q[taddr] != '0)) slc_q[taddr] <= slc_q[taddr] - 1'b1;
				end
				aftp_pkg::OP_HINC: begin
					if (slc_q[taddr] != aftp_pkg::SLICE_MAX) begin
						slc_q[taddr] <= slc_q[taddr] + 1'b1;
						pl_q         <= slc_q[taddr] + 1'b1;
					end else begin
						pl_q <= slc_q[taddr];
					end
					if (hptr_q == aftp_pkg::HPTR_W'(aftp_pkg::HIST_DEPTH - 1)) begin
						hptr_q  <= '0;
						hfull_q <= 1'b1;
					end else begin
						hptr_q <= hptr_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign status        = res_st_q;
	assign picked_slot   = res_slot_q;
	assign picked_slices = res_slc_q;

	a_qlen_matches_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == aftp_pkg::OP_IDLE) |-> ($countones(queued_q) == 32'(qlen_q)))
		else $error("queue length disagrees with queued flags");

	a_qlen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qlen_q <= aftp_pkg::QLEN_W'(NS))
		else $error("queue length beyond table size");

	a_hptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hptr_q < aftp_pkg::HPTR_W'(aftp_pkg::HIST_DEPTH))
		else $error("history pointer out of range");

	a_pick_leaves_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == aftp_pkg::OP_HINC) |-> !queued_q[pslot_q])
		else $error("picked slot still queued");

endmodule

// File: hw/rtl/affinity_fair_task_picker.sv
// ----------------------------------------------------------------------------
// affinity_fair_task_picker: affinity aware fair task picker, one item at a time
// Update, append: execute, then respond. Remove: find the slot, close the gap
// behind it and respond. Pick: scan the queue with an 18-step divide per
// eligible queued task, fall back if none, shift the pick out, update the history.
// Reset clears table, queue and history pointer at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module affinity_fair_task_picker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        mode,
	input  logic [aftp_pkg::SLOT_W-1:0]       slot,
	input  logic [aftp_pkg::CPU_W-1:0]        cpu,
	input  logic [aftp_pkg::GRP_W-1:0]        group_number,
	input  logic [aftp_pkg::WL_W-1:0]         workload,
	input  logic [aftp_pkg::NICE_W-1:0]       niceness,
	input  logic [aftp_pkg::AFF_W-1:0]        cpu_mask,
	input  logic                              kernel_task,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic [aftp_pkg::SLOT_W-1:0]       picked_slot,
	output logic [aftp_pkg::SLICE_W-1:0]      picked_slices
);

	// The controller walks each item through its steps and issues one
	// command per cycle; the datapath reports back the conditions that
	// steer the walk.
	aftp_pkg::cmd_t cmd;
	aftp_pkg::sts_t sts;

	// The controller holds the input stalled while an item is in work and
	// presents the result register to the output side.
	aftp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the task table, the ready queue, the history ring
	// and the divider that computes each candidate's normalized load.
	aftp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.mode          (mode),
		.slot          (slot),
		.cpu           (cpu),
		.group_number  (group_number),
		.workload      (workload),
		.niceness      (niceness),
		.cpu_mask      (cpu_mask),
		.kernel_task   (kernel_task),
		.status        (status),
		.picked_slot   (picked_slot),
		.picked_slices (picked_slices)
	);

endmodule
